// ===== design/ssvg_pkg.sv =====
package ssvg_pkg;

    localparam int INDEX_BITS  = 16;
    localparam int TRIG_STAGES = 16;
    localparam int TABLE_LEN   = 24;
    localparam int ROT_STAGES  = (TRIG_STAGES < TABLE_LEN) ? TRIG_STAGES : TABLE_LEN;
    localparam int ROT_SHIFT_W = 5;

    localparam int PIDX_W      = 16;
    localparam int ARMS_W      = 8;
    localparam int PROD_W      = PIDX_W + ARMS_W;
    localparam int MOD_STEPS   = ARMS_W;
    localparam int MOD_SHIFT_W = 3;

    localparam int ROT_W       = 34;
    localparam int TRIG_W      = 18;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] CFG_NUM_POINTS = 3'd0;
    localparam logic [2:0] CFG_NUM_ARMS   = 3'd1;
    localparam logic [2:0] CFG_BOX_MIN_X  = 3'd2;
    localparam logic [2:0] CFG_BOX_MIN_Y  = 3'd3;
    localparam logic [2:0] CFG_BOX_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_ARM_RATIO  = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [PIDX_W-1:0] idx;
        logic [PROD_W-1:0] rem;
    } t_mod_data;

    typedef struct packed {
        logic                  valid;
        logic [PIDX_W-1:0]     rem_a;
        logic [INDEX_BITS-1:0] q_a;
        logic [PIDX_W-1:0]     rem_b;
        logic [INDEX_BITS-1:0] q_b;
    } t_div_data;

    typedef struct packed {
        logic                    valid;
        logic                    neg;
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] t;
    } t_rot_data;

    // Arc tangent of 2^-k in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [ROT_SHIFT_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004757;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ssvg_mod_cell.sv =====
module ssvg_mod_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [ssvg_pkg::PIDX_W-1:0]         i_n,
    input  logic [ssvg_pkg::MOD_SHIFT_W-1:0]    i_shift,
    input  ssvg_pkg::t_mod_data                 i_d,
    output ssvg_pkg::t_mod_data                 o_d
);

    logic [ssvg_pkg::PROD_W-1:0] w_sub;
    ssvg_pkg::t_mod_data         r_d;
    ssvg_pkg::t_mod_data         n_d;

    assign w_sub = {{(ssvg_pkg::PROD_W-ssvg_pkg::PIDX_W){1'b0}}, i_n} << i_shift;

    // One restoring step of the remainder against n shifted up.
    always_comb begin
        n_d = i_d;
        if (i_d.rem >= w_sub) begin
            n_d.rem = i_d.rem - w_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== design/ssvg_div_cell.sv =====
module ssvg_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [ssvg_pkg::PIDX_W-1:0] i_n,
    input  ssvg_pkg::t_div_data         i_d,
    output ssvg_pkg::t_div_data         o_d
);

    localparam int IB = ssvg_pkg::INDEX_BITS;

    logic [ssvg_pkg::PIDX_W:0] w_ta;
    logic [ssvg_pkg::PIDX_W:0] w_tb;
    logic [ssvg_pkg::PIDX_W:0] w_n;
    logic                      w_ge_a;
    logic                      w_ge_b;
    ssvg_pkg::t_div_data       r_d;
    ssvg_pkg::t_div_data       n_d;

    assign w_n    = {1'b0, i_n};
    assign w_ta   = {i_d.rem_a, 1'b0};
    assign w_tb   = {i_d.rem_b, 1'b0};
    assign w_ge_a = (w_ta >= w_n);
    assign w_ge_b = (w_tb >= w_n);

    // One quotient bit of each of the two phase divisions.
    always_comb begin
        n_d       = i_d;
        n_d.rem_a = w_ge_a ? ssvg_pkg::PIDX_W'(w_ta - w_n) : w_ta[ssvg_pkg::PIDX_W-1:0];
        n_d.rem_b = w_ge_b ? ssvg_pkg::PIDX_W'(w_tb - w_n) : w_tb[ssvg_pkg::PIDX_W-1:0];
        n_d.q_a   = {i_d.q_a[IB-2:0], w_ge_a};
        n_d.q_b   = {i_d.q_b[IB-2:0], w_ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== design/ssvg_cordic_cell.sv =====
module ssvg_cordic_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic [ssvg_pkg::ROT_SHIFT_W-1:0] i_shift,
    input  ssvg_pkg::t_rot_data              i_d,
    output ssvg_pkg::t_rot_data              o_d
);

    logic signed [ssvg_pkg::ROT_W-1:0] w_dx;
    logic signed [ssvg_pkg::ROT_W-1:0] w_dy;
    logic signed [ssvg_pkg::ROT_W-1:0] w_at;
    ssvg_pkg::t_rot_data               r_d;
    ssvg_pkg::t_rot_data               n_d;

    assign w_dx = i_d.y >>> i_shift;
    assign w_dy = i_d.x >>> i_shift;
    assign w_at = $signed({2'b00, ssvg_pkg::atan_turn(i_shift)});

    always_comb begin
        n_d = i_d;
        if (!i_d.t[ssvg_pkg::ROT_W-1]) begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.t = i_d.t - w_at;
        end else begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.t = i_d.t + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== design/sine_star_vertex_generator_unit.sv =====
// Sine-star vertex generator.
// Input channel: i_valid / o_stall with i_point_index; a request is taken at
// a rising edge with i_valid high and o_stall low. Output channel: o_valid /
// i_stall with o_vertex_x and o_vertex_y, taken when o_valid is high and
// i_stall is low.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data.
// o_cfg_ready is always high; indexes six and seven are ignored. Write only
// while no request is in flight.
// Throughput is one vertex per cycle while the receiver does not stall. A
// request passes through the chains of remainder cells, divider cells and
// rotator cells and then the registers of the split multipliers.
// When the receiver stalls a finished result, the whole pipeline holds and
// o_stall rises in the same cycle; it falls again once the result is taken.
// Reset is synchronous and active low: it empties the pipeline and loads the
// default register values (64 points, 5 arms, box at 0,0 of width 100, arm
// ratio one half).
module sine_star_vertex_generator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [15:0]                 i_point_index,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_vertex_x,
    output logic signed [31:0]          o_vertex_y,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);

    localparam int IB = ssvg_pkg::INDEX_BITS;
    localparam int NR = ssvg_pkg::ROT_STAGES;
    localparam int MS = ssvg_pkg::MOD_STEPS;
    localparam int RW = ssvg_pkg::ROT_W;
    localparam int TW = ssvg_pkg::TRIG_W;

    localparam logic signed [RW-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [RW-1:0] HALF    = 34'sd2147483648;

    // Configuration registers
    logic [15:0]        r_num_points;
    logic [7:0]         r_num_arms;
    logic signed [31:0] r_box_min_x;
    logic signed [31:0] r_box_min_y;
    logic [30:0]        r_box_width;
    logic [16:0]        r_arm_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= 16'd64;
            r_num_arms   <= 8'd5;
            r_box_min_x  <= 32'sd0;
            r_box_min_y  <= 32'sd0;
            r_box_width  <= 31'd100;
            r_arm_ratio  <= 17'd32768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssvg_pkg::CFG_NUM_POINTS: r_num_points <= i_cfg_data[15:0];
                ssvg_pkg::CFG_NUM_ARMS:   r_num_arms   <= i_cfg_data[7:0];
                ssvg_pkg::CFG_BOX_MIN_X:  r_box_min_x  <= $signed(i_cfg_data);
                ssvg_pkg::CFG_BOX_MIN_Y:  r_box_min_y  <= $signed(i_cfg_data);
                ssvg_pkg::CFG_BOX_WIDTH:  r_box_width  <= i_cfg_data[30:0];
                ssvg_pkg::CFG_ARM_RATIO:  r_arm_ratio  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Values that follow from the registers alone; they are registered after a
    // write and settle long before the first vertex reaches them.
    logic [16:0]        w_ratio;
    logic [32:0]        r_aw_lo;
    logic [31:0]        r_aw_hi;
    logic [46:0]        r_arm;
    logic [46:0]        r_core;
    logic signed [51:0] r_base_x;
    logic signed [51:0] r_base_y;
    logic [47:0]        w_aw;
    logic signed [51:0] w_half_w;

    assign w_ratio  = (r_arm_ratio > 17'd65536) ? 17'd65536 : r_arm_ratio;
    assign w_aw     = ({16'd0, r_aw_hi} << 16) + {15'd0, r_aw_lo};
    assign w_half_w = $signed({6'd0, r_box_width, 15'd0});

    always_ff @(posedge i_clk) begin
        r_aw_lo  <= w_ratio * r_box_width[15:0];
        r_aw_hi  <= w_ratio * r_box_width[30:16];
        r_arm    <= w_aw[47:1];
        r_core   <= {1'b0, r_box_width, 15'd0} - r_arm;
        r_base_x <= (52'(r_box_min_x) <<< 16) + w_half_w;
        r_base_y <= (52'(r_box_min_y) <<< 16) + w_half_w;
    end

    // Flow control: the pipeline moves as one while the output is free.
    logic w_adv;
    logic r_o_valid;

    assign w_adv   = !r_o_valid || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_o_valid;

    logic [15:0] w_n;
    logic [15:0] w_idx;

    assign w_n   = (r_num_points == 16'd0) ? 16'd1 : r_num_points;
    assign w_idx = (i_point_index >= w_n) ? 16'd0 : i_point_index;

    // Remainder of index times arms, one restoring step per cell.
    ssvg_pkg::t_mod_data w_mod [0:MS];

    assign w_mod[0].valid = i_valid;
    assign w_mod[0].idx   = w_idx;
    assign w_mod[0].rem   = w_idx * r_num_arms;

    for (genvar g = 0; g < MS; g++) begin : g_mod
        ssvg_mod_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_n     (w_n),
            .i_shift (ssvg_pkg::MOD_SHIFT_W'(MS - 1 - g)),
            .i_d     (w_mod[g]),
            .o_d     (w_mod[g+1])
        );
    end

    // Arm phase and angle phase, one quotient bit per cell.
    ssvg_pkg::t_div_data w_div [0:IB];

    assign w_div[0].valid = w_mod[MS].valid;
    assign w_div[0].rem_a = w_mod[MS].rem[15:0];
    assign w_div[0].q_a   = '0;
    assign w_div[0].rem_b = w_mod[MS].idx;
    assign w_div[0].q_b   = '0;

    for (genvar g = 0; g < IB; g++) begin : g_div
        ssvg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_n     (w_n),
            .i_d     (w_div[g]),
            .o_d     (w_div[g+1])
        );
    end

    // Fold the turn into a quarter either side of zero, then rotate.
    function automatic ssvg_pkg::t_rot_data fold(input logic valid,
                                                 input logic [IB-1:0] ph);
        logic signed [31:0]   p32;
        ssvg_pkg::t_rot_data  d;
        p32     = {ph, {(32-IB){1'b0}}};
        d.valid = valid;
        d.x     = ssvg_pkg::CORDIC_GAIN;
        d.y     = '0;
        d.t     = RW'(p32);
        d.neg   = 1'b0;
        if (d.t > QUARTER) begin
            d.t   = d.t - HALF;
            d.neg = 1'b1;
        end else if (d.t < -QUARTER) begin
            d.t   = d.t + HALF;
            d.neg = 1'b1;
        end
        return d;
    endfunction

    ssvg_pkg::t_rot_data w_rot_a [0:NR];
    ssvg_pkg::t_rot_data w_rot_b [0:NR];

    assign w_rot_a[0] = fold(w_div[IB].valid, w_div[IB].q_a);
    assign w_rot_b[0] = fold(w_div[IB].valid, w_div[IB].q_b);

    for (genvar g = 0; g < NR; g++) begin : g_rot
        ssvg_cordic_cell u_arm (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_shift (ssvg_pkg::ROT_SHIFT_W'(g)),
            .i_d     (w_rot_a[g]),
            .o_d     (w_rot_a[g+1])
        );
        ssvg_cordic_cell u_ang (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_shift (ssvg_pkg::ROT_SHIFT_W'(g)),
            .i_d     (w_rot_b[g]),
            .o_d     (w_rot_b[g+1])
        );
    end

    function automatic logic signed [TW-1:0] trig_round(input logic signed [RW-1:0] v,
                                                        input logic neg);
        logic signed [RW-1:0] f;
        logic signed [RW-1:0] r;
        logic signed [TW-1:0] q;
        f = neg ? -v : v;
        r = (f + 34'sd8192) >>> 14;
        if (r > 34'sd65536) begin
            q = 18'sd65536;
        end else if (r < -34'sd65536) begin
            q = -18'sd65536;
        end else begin
            q = r[TW-1:0];
        end
        return q;
    endfunction

    // Back end: rounding, radius, products and saturation.
    logic                 r_v_post, r_v_a, r_v_b, r_v_c, r_v_d, r_v_e;
    logic signed [TW-1:0] r_ac, r_c, r_s, r_c_a, r_s_a, r_c_b, r_s_b;
    logic [40:0]          r_ph_hi;
    logic [41:0]          r_ph_lo;
    logic [46:0]          r_curve;
    logic signed [42:0]   r_xlo, r_ylo;
    logic signed [41:0]   r_xhi, r_yhi;
    logic signed [49:0]   r_qx, r_qy;
    logic signed [51:0]   r_vx, r_vy;
    logic signed [31:0]   r_out_x, r_out_y;

    logic [TW-1:0]        w_cval;
    logic [65:0]          w_sum;
    logic signed [65:0]   w_px, w_py;
    logic signed [51:0]   w_rx, w_ry;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign w_cval = unsigned'(r_ac + 18'sd65536);
    assign w_sum  = ({25'd0, r_ph_hi} << 24) + {24'd0, r_ph_lo};
    assign w_px   = (66'(r_xhi) <<< 24) + 66'(r_xlo);
    assign w_py   = (66'(r_yhi) <<< 24) + 66'(r_ylo);
    // Truncation toward zero of a value in units of 2^-16.
    assign w_rx   = r_vx[51] ? ((r_vx + 52'sd65535) >>> 16) : (r_vx >>> 16);
    assign w_ry   = r_vy[51] ? ((r_vy + 52'sd65535) >>> 16) : (r_vy >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_post  <= 1'b0;
            r_v_a     <= 1'b0;
            r_v_b     <= 1'b0;
            r_v_c     <= 1'b0;
            r_v_d     <= 1'b0;
            r_v_e     <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_v_post  <= w_rot_a[NR].valid;
            r_v_a     <= r_v_post;
            r_v_b     <= r_v_a;
            r_v_c     <= r_v_b;
            r_v_d     <= r_v_c;
            r_v_e     <= r_v_d;
            r_o_valid <= r_v_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ac    <= trig_round(w_rot_a[NR].x, w_rot_a[NR].neg);
            r_c     <= trig_round(w_rot_b[NR].x, w_rot_b[NR].neg);
            r_s     <= trig_round(w_rot_b[NR].y, w_rot_b[NR].neg);

            r_ph_hi <= r_arm[46:24] * w_cval;
            r_ph_lo <= r_arm[23:0] * w_cval;
            r_c_a   <= r_c;
            r_s_a   <= r_s;

            r_curve <= r_core + w_sum[63:17];
            r_c_b   <= r_c_a;
            r_s_b   <= r_s_a;

            r_xlo   <= $signed({1'b0, r_curve[23:0]}) * r_c_b;
            r_xhi   <= $signed({1'b0, r_curve[46:24]}) * r_c_b;
            r_ylo   <= $signed({1'b0, r_curve[23:0]}) * r_s_b;
            r_yhi   <= $signed({1'b0, r_curve[46:24]}) * r_s_b;

            r_qx    <= w_px[65:16];
            r_qy    <= w_py[65:16];

            r_vx    <= r_base_x + 52'(r_qx);
            r_vy    <= r_base_y + 52'(r_qy);

            r_out_x <= sat32(w_rx);
            r_out_y <= sat32(w_ry);
        end
    end

    assign o_vertex_x = r_out_x;
    assign o_vertex_y = r_out_y;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty output register");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod[MS].valid |-> (w_mod[MS].rem < {8'd0, w_n}))
        else $error("arm remainder not below the vertex count");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div[IB].valid |-> (w_div[IB].rem_a < w_n && w_div[IB].rem_b < w_n))
        else $error("phase division remainder out of range");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_post |-> (r_ac <= 18'sd65536 && r_ac >= -18'sd65536))
        else $error("arm cosine outside its clamp");

endmodule
